FILE: src/restoring_unsigned_divider_assert.svh
// Assertion macros shared by the divider's checker.
// No dependencies; include guarded.
`ifndef RESTORING_UNSIGNED_DIVIDER_ASSERT_SVH
`define RESTORING_UNSIGNED_DIVIDER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RUD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("divider assertion failed");

// Next-cycle implication, disabled during reset.
`define RUD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("divider assertion failed");

`endif

FILE: src/rud_pkg.sv
// Shared types for the restoring unsigned divider.
// No dependencies.
package rud_pkg;

	// Per-stage pipeline control: request present and global advance.
	typedef struct packed {
		logic valid;
		logic advance;
	} rud_ctrl_t;

endpackage

FILE: src/rud_cell.sv
// One restoring division step: shift in a dividend bit, trial subtract, keep or restore.
// Depends on rud_pkg.
module rud_cell import rud_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rud_ctrl_t             ctrl,
	input  logic [DATA_WIDTH-1:0] rem_in,
	input  logic [DATA_WIDTH-1:0] num_in,
	input  logic [DATA_WIDTH-1:0] den_in,
	input  logic [DATA_WIDTH-1:0] quo_in,
	output logic                  valid_out,
	output logic [DATA_WIDTH-1:0] rem_out,
	output logic [DATA_WIDTH-1:0] num_out,
	output logic [DATA_WIDTH-1:0] den_out,
	output logic [DATA_WIDTH-1:0] quo_out
);

	logic [DATA_WIDTH:0]   trial;
	logic [DATA_WIDTH:0]   diff;
	logic                  fits;

	logic                  valid_q;
	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH-1:0] num_q;
	logic [DATA_WIDTH-1:0] den_q;
	logic [DATA_WIDTH-1:0] quo_q;

	// Partial remainder can reach the divisor's top bit, so the shift keeps one extra bit
	assign trial = {rem_in, num_in[DATA_WIDTH-1]};
	assign diff  = trial - {1'b0, den_in};
	assign fits  = (trial >= {1'b0, den_in});

	// Valid bit of this stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.advance) begin
			valid_q <= ctrl.valid;
		end
	end

	// Stage payload; the kept remainder is below the divisor, so it fits in DATA_WIDTH bits
	always_ff @(posedge clk) begin
		if (ctrl.advance) begin
			rem_q <= fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
			num_q <= {num_in[DATA_WIDTH-2:0], 1'b0};
			den_q <= den_in;
			quo_q <= {quo_in[DATA_WIDTH-2:0], fits};
		end
	end

	assign valid_out = valid_q;
	assign rem_out   = rem_q;
	assign num_out   = num_q;
	assign den_out   = den_q;
	assign quo_out   = quo_q;

endmodule

FILE: src/rud_out_buf.sv
// Output register with one skid entry; its ready is registered and freezes the cell chain.
// No dependencies.
module rud_out_buf #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DATA_WIDTH-1:0] in_quo,
	input  logic [DATA_WIDTH-1:0] in_rem,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DATA_WIDTH-1:0] out_quo,
	output logic [DATA_WIDTH-1:0] out_rem
);

	logic                  out_valid_q;
	logic                  skid_valid_q;
	logic [DATA_WIDTH-1:0] out_quo_q;
	logic [DATA_WIDTH-1:0] out_rem_q;
	logic [DATA_WIDTH-1:0] skid_quo_q;
	logic [DATA_WIDTH-1:0] skid_rem_q;
	logic                  out_take;

	assign in_ready = !skid_valid_q;
	assign out_take = !out_valid_q || !out_stall;

	// Occupancy of output and skid entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_take) begin
			out_valid_q  <= skid_valid_q || in_valid;
			skid_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload: output refills from skid first, else from the chain
	always_ff @(posedge clk) begin
		if (out_take) begin
			out_quo_q <= skid_valid_q ? skid_quo_q : in_quo;
			out_rem_q <= skid_valid_q ? skid_rem_q : in_rem;
		end else if (in_valid && in_ready) begin
			skid_quo_q <= in_quo;
			skid_rem_q <= in_rem;
		end
	end

	assign out_valid = out_valid_q;
	assign out_quo   = out_quo_q;
	assign out_rem   = out_rem_q;

endmodule

FILE: src/restoring_unsigned_divider.sv
// Pipelined restoring unsigned divider: DATA_WIDTH step cells then an output buffer.
// One request per cycle is sustained while req_stall is low.
// Each cell resolves one quotient bit; the skid entry lets one request in while a result stalls.
// Reset (arst_n, async, active low) clears all valid bits; no stored state between requests.
// Depends on rud_pkg, rud_cell, rud_out_buf.
module restoring_unsigned_divider import rud_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output logic [DATA_WIDTH-1:0] quotient,
	output logic [DATA_WIDTH-1:0] remainder
);

	logic                  advance;
	logic                  valid_w [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] rem_w   [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] num_w   [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] den_w   [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] quo_w   [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] quo_fix;

	assign req_stall = !advance;

	// Head of the chain: fresh request with empty remainder and quotient
	assign valid_w[0] = req_valid;
	assign rem_w[0]   = '0;
	assign num_w[0]   = dividend;
	assign den_w[0]   = divisor;
	assign quo_w[0]   = '0;

	// One cell per quotient bit, MSB first
	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
		rud_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      ('{valid: valid_w[i], advance: advance}),
			.rem_in    (rem_w[i]),
			.num_in    (num_w[i]),
			.den_in    (den_w[i]),
			.quo_in    (quo_w[i]),
			.valid_out (valid_w[i+1]),
			.rem_out   (rem_w[i+1]),
			.num_out   (num_w[i+1]),
			.den_out   (den_w[i+1]),
			.quo_out   (quo_w[i+1])
		);
	end

	// Zero divisor: every trial fits, so force the quotient to zero; remainder is the dividend
	assign quo_fix = (den_w[DATA_WIDTH] == '0) ? '0 : quo_w[DATA_WIDTH];

	rud_out_buf #(.DATA_WIDTH(DATA_WIDTH)) u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_w[DATA_WIDTH]),
		.in_ready  (advance),
		.in_quo    (quo_fix),
		.in_rem    (rem_w[DATA_WIDTH]),
		.out_valid (rsp_valid),
		.out_stall (rsp_stall),
		.out_quo   (quotient),
		.out_rem   (remainder)
	);

endmodule

FILE: src/rud_check.sv
// Port-level checker for the divider, bound to the top level.
// Depends on restoring_unsigned_divider_assert.svh.
`include "restoring_unsigned_divider_assert.svh"

module rud_check #(
	parameter int DATA_WIDTH = 32
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_stall,
	input logic                  rsp_valid,
	input logic                  rsp_stall,
	input logic [DATA_WIDTH-1:0] quotient,
	input logic [DATA_WIDTH-1:0] remainder
);

	logic rsp_held;
	logic req_blocked;

	assign rsp_held    = rsp_valid && rsp_stall;
	assign req_blocked = req_valid && req_stall;

	// A stalled result keeps its request and payload
	`RUD_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_held, rsp_valid)
	`RUD_ASSERT_NEXT(a_rsp_stable, clk, arst_n, rsp_held, $stable(quotient) && $stable(remainder))

	// Input stalls only while a result is held in the output register
	`RUD_ASSERT_NOW(a_stall_has_rsp, clk, arst_n, req_stall, rsp_valid)

	// Once the output drains, the skid entry empties and input reopens
	`RUD_ASSERT_NEXT(a_stall_clears, clk, arst_n, req_stall && !rsp_stall, !req_stall)

	// A request blocked as the input stall rises implies the output was stalled last cycle
	`RUD_ASSERT_NOW(a_block_cause, clk, arst_n, req_blocked && $rose(req_stall),
		$past(rsp_held))

endmodule

bind restoring_unsigned_divider rud_check #(.DATA_WIDTH(DATA_WIDTH)) u_rud_check (.*);
